[rtl/dsft_pkg.sv]
// Shared constants, codes and the result record of the distinct symbol
// frequency table. No dependencies; used by the top level.
`timescale 1ns / 1ps

package dsft_pkg;

  // Table geometry.
  localparam int unsigned TABLE_DEPTH = 256;
  localparam int unsigned COUNT_WIDTH = 32;
  localparam int unsigned IDX_W  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned DCNT_W = $clog2(TABLE_DEPTH + 1);

  // Field widths of the item and result beats.
  localparam int unsigned OP_W       = 2;
  localparam int unsigned CODE_W     = 21;
  localparam int unsigned ENTRY_W    = 8;
  localparam int unsigned STATUS_W   = 3;
  localparam int unsigned SLOT_W     = 8;
  localparam int unsigned OUT_CNT_W  = 32;
  localparam int unsigned DIST_OUT_W = 9;
  localparam int unsigned TOTAL_W    = 32;
  localparam int unsigned WORD_W     = CODE_W + COUNT_WIDTH;
  localparam int unsigned CMP_W      = (DCNT_W > ENTRY_W) ? DCNT_W : ENTRY_W;

  // Configuration port.
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_FILTER_MODE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_KEEP_CASE   = 2'd1;

  localparam logic [CODE_W-1:0] BOM_CODE = 21'h00FEFF;

  // Operations.
  localparam logic [OP_W-1:0] OP_COUNT = 2'd0;
  localparam logic [OP_W-1:0] OP_READ  = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

  // Result status codes.
  localparam logic [STATUS_W-1:0] ST_HIT      = 3'd0;
  localparam logic [STATUS_W-1:0] ST_NEW      = 3'd1;
  localparam logic [STATUS_W-1:0] ST_BOM      = 3'd2;
  localparam logic [STATUS_W-1:0] ST_FILTERED = 3'd3;
  localparam logic [STATUS_W-1:0] ST_FULL     = 3'd4;
  localparam logic [STATUS_W-1:0] ST_IGNORED  = 3'd5;
  localparam logic [STATUS_W-1:0] ST_READ     = 3'd6;
  localparam logic [STATUS_W-1:0] ST_CLEARED  = 3'd7;

  typedef struct packed {
    logic [STATUS_W-1:0]   status;
    logic [SLOT_W-1:0]     slot;
    logic [CODE_W-1:0]     entry_code;
    logic [OUT_CNT_W-1:0]  entry_count;
    logic [DIST_OUT_W-1:0] distinct_total;
    logic [TOTAL_W-1:0]    character_total;
  } result_t;

endpackage

[rtl/dsft_ram.sv]
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
`timescale 1ns / 1ps

module dsft_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                                        clk_i,
  input  logic                                        we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                            wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                            rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

[rtl/distinct_symbol_frequency_table.sv]
// Top level of the distinct symbol frequency table: sequencer, totals and
// output register. Depends on dsft_pkg and dsft_ram.
`timescale 1ns / 1ps

// The block takes one item at a time and holds in_stall_o high while it
// works on it. A clear or a dropped character (byte-order mark, filtered,
// ignored after error) passes from acceptance through S_PUSH back to
// idle; a table read passes through S_READ and then S_PUSH. A counted
// character walks the table from slot 0, one stored entry per cycle
// through the single read port of the symbol RAM, until it matches an
// entry or is appended after the last one, and then passes through
// S_PUSH. A character that finds the table full has walked every
// entry, the longest walk of any item. Results leave through an
// output register, so the core takes the next item while a finished result
// still waits for the consumer; a second result waits in the core until
// that register is free. Configuration writes are always ready and must
// only be issued while the block is idle. The table RAM needs no clearing
// pass: entries at or past the distinct count are never read, so a clear
// takes effect at once.

module distinct_symbol_frequency_table (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // Configuration write channel.
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [dsft_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [dsft_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  // Item channel.
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic [dsft_pkg::OP_W-1:0]          opcode_i,
  input  logic [dsft_pkg::CODE_W-1:0]        code_point_i,
  input  logic [dsft_pkg::CODE_W-1:0]        folded_code_i,
  input  logic                               is_control_i,
  input  logic                               is_space_i,
  input  logic                               is_punct_i,
  input  logic                               is_alpha_i,
  input  logic [dsft_pkg::ENTRY_W-1:0]       entry_index_i,
  // Result channel.
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic [dsft_pkg::STATUS_W-1:0]      status_o,
  output logic [dsft_pkg::SLOT_W-1:0]        slot_o,
  output logic [dsft_pkg::CODE_W-1:0]        entry_code_o,
  output logic [dsft_pkg::OUT_CNT_W-1:0]     entry_count_o,
  output logic [dsft_pkg::DIST_OUT_W-1:0]    distinct_total_o,
  output logic [dsft_pkg::TOTAL_W-1:0]       character_total_o
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_READ = 2'd1;
  localparam logic [1:0] S_SCAN = 2'd2;
  localparam logic [1:0] S_PUSH = 2'd3;

  localparam int unsigned CW = dsft_pkg::COUNT_WIDTH;

  logic [1:0]                       state_q, state_d;
  logic [dsft_pkg::IDX_W-1:0]       ptr_q, ptr_d;
  logic [dsft_pkg::CODE_W-1:0]      code_q, code_d;
  logic [dsft_pkg::DCNT_W-1:0]      distinct_q, distinct_d;
  logic [dsft_pkg::TOTAL_W-1:0]     total_q, total_d;
  logic                             first_seen_q, first_seen_d;
  logic                             full_q, full_d;
  logic                             rd_hit_q, rd_hit_d;
  logic [1:0]                       filter_mode_q;
  logic                             keep_case_q;
  dsft_pkg::result_t                res_q, res_d;
  dsft_pkg::result_t                out_q;
  logic                             out_valid_q, out_valid_d;
  logic                             out_load;

  logic                             ram_we;
  logic [dsft_pkg::IDX_W-1:0]       ram_waddr;
  logic [dsft_pkg::WORD_W-1:0]      ram_wdata;
  logic [dsft_pkg::IDX_W-1:0]       ram_raddr;
  logic [dsft_pkg::WORD_W-1:0]      ram_rdata;
  logic [dsft_pkg::CODE_W-1:0]      rd_code;
  logic [CW-1:0]                    rd_count;
  logic [CW-1:0]                    new_count;
  logic [dsft_pkg::TOTAL_W-1:0]     total_inc;

  logic                             in_acc;
  logic                             filtered;
  logic                             in_range;
  logic                             do_append;
  logic                             load_res;
  logic [dsft_pkg::CODE_W-1:0]      sel_code;
  logic [dsft_pkg::CODE_W-1:0]      cur_code;

  dsft_ram #(
    .WIDTH (dsft_pkg::WORD_W),
    .DEPTH (dsft_pkg::TABLE_DEPTH)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign rd_code  = ram_rdata[dsft_pkg::WORD_W-1 -: dsft_pkg::CODE_W];
  assign rd_count = ram_rdata[CW-1:0];
  assign new_count = (rd_count == {CW{1'b1}}) ? rd_count : rd_count + CW'(1);
  assign total_inc = (total_q == {dsft_pkg::TOTAL_W{1'b1}}) ? total_q
                                                            : total_q + 32'd1;

  assign in_stall_o  = (state_q != S_IDLE);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;

  assign sel_code = keep_case_q ? code_point_i : folded_code_i;
  assign in_range = (dsft_pkg::CMP_W'(entry_index_i) < dsft_pkg::CMP_W'(distinct_q));

  always_comb begin
    unique case (filter_mode_q)
      2'd0:    filtered = is_control_i;
      2'd1:    filtered = is_control_i || is_space_i;
      2'd2:    filtered = is_control_i || is_space_i || is_punct_i;
      default: filtered = !is_alpha_i;
    endcase
  end

  // Read address: the next slot while scanning, so the RAM streams one
  // entry per cycle; otherwise the slot a read item asks for, or slot 0.
  always_comb begin
    if (state_q == S_SCAN) begin
      ram_raddr = ptr_q + dsft_pkg::IDX_W'(1);
    end else if (opcode_i == dsft_pkg::OP_READ) begin
      ram_raddr = dsft_pkg::IDX_W'(entry_index_i);
    end else begin
      ram_raddr = '0;
    end
  end

  always_comb begin
    state_d      = state_q;
    ptr_d        = ptr_q;
    code_d       = code_q;
    distinct_d   = distinct_q;
    total_d      = total_q;
    first_seen_d = first_seen_q;
    full_d       = full_q;
    rd_hit_d     = rd_hit_q;
    res_d        = res_q;
    ram_we       = 1'b0;
    ram_waddr    = ptr_q;
    ram_wdata    = {code_q, new_count};
    do_append    = 1'b0;
    load_res     = 1'b0;
    out_load     = 1'b0;
    cur_code     = code_q;

    unique case (state_q)
      S_IDLE: begin
        cur_code = sel_code;
        if (in_acc) begin
          unique case (opcode_i)
            dsft_pkg::OP_CLEAR: begin
              distinct_d   = '0;
              total_d      = '0;
              first_seen_d = 1'b0;
              full_d       = 1'b0;
              res_d        = '0;
              res_d.status = dsft_pkg::ST_CLEARED;
              load_res     = 1'b1;
              state_d      = S_PUSH;
            end
            dsft_pkg::OP_READ: begin
              res_d        = '0;
              res_d.status = dsft_pkg::ST_READ;
              res_d.slot   = entry_index_i;
              rd_hit_d     = in_range;
              state_d      = S_READ;
            end
            dsft_pkg::OP_COUNT: begin
              res_d = '0;
              if (full_q) begin
                res_d.status = dsft_pkg::ST_IGNORED;
                load_res     = 1'b1;
                state_d      = S_PUSH;
              end else if (!first_seen_q && code_point_i == dsft_pkg::BOM_CODE) begin
                first_seen_d = 1'b1;
                res_d.status = dsft_pkg::ST_BOM;
                load_res     = 1'b1;
                state_d      = S_PUSH;
              end else begin
                first_seen_d = 1'b1;
                if (filtered) begin
                  res_d.status = dsft_pkg::ST_FILTERED;
                  load_res     = 1'b1;
                  state_d      = S_PUSH;
                end else if (distinct_q == '0) begin
                  do_append = 1'b1;
                end else begin
                  code_d  = sel_code;
                  ptr_d   = '0;
                  state_d = S_SCAN;
                end
              end
            end
            default: begin
              // The unused opcode is consumed without a result.
            end
          endcase
        end
      end

      S_READ: begin
        if (rd_hit_q) begin
          res_d.entry_code  = rd_code;
          res_d.entry_count = dsft_pkg::OUT_CNT_W'(rd_count);
        end
        load_res = 1'b1;
        state_d  = S_PUSH;
      end

      S_SCAN: begin
        if (rd_code == code_q) begin
          ram_we            = 1'b1;
          total_d           = total_inc;
          res_d.status      = dsft_pkg::ST_HIT;
          res_d.slot        = dsft_pkg::SLOT_W'(ptr_q);
          res_d.entry_code  = code_q;
          res_d.entry_count = dsft_pkg::OUT_CNT_W'(new_count);
          load_res          = 1'b1;
          state_d           = S_PUSH;
        end else if (dsft_pkg::DCNT_W'(ptr_q) + dsft_pkg::DCNT_W'(1) == distinct_q) begin
          do_append = 1'b1;
        end else begin
          ptr_d = ptr_q + dsft_pkg::IDX_W'(1);
        end
      end

      default: begin
        // S_PUSH: hand the result over once the output register is free.
        if (!out_valid_q || !out_stall_i) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end
    endcase

    if (do_append) begin
      res_d    = '0;
      load_res = 1'b1;
      state_d  = S_PUSH;
      if (distinct_q != dsft_pkg::DCNT_W'(dsft_pkg::TABLE_DEPTH)) begin
        ram_we            = 1'b1;
        ram_waddr         = distinct_q[dsft_pkg::IDX_W-1:0];
        ram_wdata         = {cur_code, CW'(1)};
        distinct_d        = distinct_q + dsft_pkg::DCNT_W'(1);
        total_d           = total_inc;
        res_d.status      = dsft_pkg::ST_NEW;
        res_d.slot        = dsft_pkg::SLOT_W'(distinct_q);
        res_d.entry_code  = cur_code;
        res_d.entry_count = dsft_pkg::OUT_CNT_W'(1);
      end else begin
        full_d       = 1'b1;
        res_d.status = dsft_pkg::ST_FULL;
      end
    end

    // Every result reports the totals as they stand after its item.
    if (load_res) begin
      res_d.distinct_total  = dsft_pkg::DIST_OUT_W'(distinct_d);
      res_d.character_total = total_d;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      distinct_q    <= '0;
      total_q       <= '0;
      first_seen_q  <= 1'b0;
      full_q        <= 1'b0;
      out_valid_q   <= 1'b0;
      filter_mode_q <= 2'd0;
      keep_case_q   <= 1'b1;
    end else begin
      state_q      <= state_d;
      distinct_q   <= distinct_d;
      total_q      <= total_d;
      first_seen_q <= first_seen_d;
      full_q       <= full_d;
      out_valid_q  <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        if (cfg_index_i == dsft_pkg::CFG_FILTER_MODE) begin
          filter_mode_q <= cfg_data_i[1:0];
        end else if (cfg_index_i == dsft_pkg::CFG_KEEP_CASE) begin
          keep_case_q <= cfg_data_i[0];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    ptr_q    <= ptr_d;
    code_q   <= code_d;
    rd_hit_q <= rd_hit_d;
    res_q    <= res_d;
    if (out_load) begin
      out_q <= res_q;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign status_o          = out_q.status;
  assign slot_o            = out_q.slot;
  assign entry_code_o      = out_q.entry_code;
  assign entry_count_o     = out_q.entry_count;
  assign distinct_total_o  = out_q.distinct_total;
  assign character_total_o = out_q.character_total;

endmodule
